// ----- hw/rtl/ltc_pkg.sv -----
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types and constants for the LRU tag cache: the search token that
// walks the cell chain and the write-back bus broadcast to all cells.
// ----------------------------------------------------------------------------
package ltc_pkg;

  // Default slot count, and an index width that covers up to 1024 slots.
  localparam int LTC_SLOTS_DEF = 256;
  localparam int LTC_IDX_W     = 10;
  localparam int LTC_TAG_W     = 32;
  localparam int LTC_STAMP_W   = 64;
  localparam int LTC_SLOT_W    = 8;

  // Request codes.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_FILL   = 1'b1;

  // Search token; index fields are zero-padded to LTC_IDX_W bits.
  typedef struct packed {
    logic                   vld;
    logic                   req;
    logic [LTC_TAG_W-1:0]   id;
    logic                   found;
    logic [LTC_IDX_W-1:0]   fidx;
    logic                   stopped;
    logic [LTC_IDX_W-1:0]   vidx;
    logic [LTC_STAMP_W-1:0] vstamp;
  } tok_t;

  // Write-back bus to the cells.
  typedef struct packed {
    logic                   en;
    logic                   fill;
    logic [LTC_IDX_W-1:0]   idx;
    logic [LTC_TAG_W-1:0]   tag;
    logic [LTC_STAMP_W-1:0] stamp;
  } wr_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WB
  } state_t;

endpackage

// ----- hw/rtl/ltc_cell.sv -----
// ----------------------------------------------------------------------------
// ltc_cell
// One cache slot: holds tag, valid bit and use stamp, updates the passing
// search token with its match and victim information, and takes write-backs
// addressed to its index.
// ----------------------------------------------------------------------------
module ltc_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ltc_pkg::tok_t tok_i,
  output ltc_pkg::tok_t tok_o,
  input  ltc_pkg::wr_t  wr_i
);
  import ltc_pkg::*;

  localparam logic [LTC_IDX_W-1:0] MY_IDX = LTC_IDX_W'(IDX);
  localparam bit FIRST = (IDX == 0);

  logic                   valid_r;
  logic [LTC_TAG_W-1:0]   tag_r;
  logic [LTC_STAMP_W-1:0] stamp_r;
  logic [LTC_STAMP_W-1:0] stamp_eff;
  tok_t                   tok_r;
  tok_t                   tok_nxt;
  logic                   wr_hit;

  // An invalid slot counts with stamp zero.
  assign stamp_eff = valid_r ? stamp_r : '0;
  assign wr_hit    = wr_i.en && (wr_i.idx == MY_IDX);

  // Token update as it passes this slot.
  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.vld) begin
      if (tok_i.req == REQ_LOOKUP) begin
        if (!tok_i.found && valid_r && (tag_r == tok_i.id)) begin
          tok_nxt.found = 1'b1;
          tok_nxt.fidx  = MY_IDX;
        end
      end else if (FIRST) begin
        tok_nxt.stopped = 1'b0;
        tok_nxt.vidx    = MY_IDX;
        tok_nxt.vstamp  = stamp_eff;
      end else if (!tok_i.stopped) begin
        if (!valid_r) begin
          tok_nxt.stopped = 1'b1;
          tok_nxt.vidx    = MY_IDX;
        end else if (stamp_r < tok_i.vstamp) begin
          tok_nxt.vidx   = MY_IDX;
          tok_nxt.vstamp = stamp_r;
        end
      end
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

  // Slot valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_hit && wr_i.fill) begin
      valid_r <= 1'b1;
    end
  end

  // Slot tag and stamp.
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      stamp_r <= wr_i.stamp;
      if (wr_i.fill) begin
        tag_r <= wr_i.tag;
      end
    end
  end

endmodule

// ----- hw/rtl/lru_tag_cache_unit.sv -----
// ----------------------------------------------------------------------------
// lru_tag_cache_unit
// Fully associative tag cache with timestamp LRU replacement, built as a
// chain of slot cells that a search token walks one slot per cycle.
// ----------------------------------------------------------------------------
// Each word goes through these steps from acceptance to its result being
// offered: the accepting edge loads the search token into the first slot
// cell and it moves on one cell per cycle, the captured-token register
// takes it from the last cell, and the write-back cycle updates the stamp
// and tag and loads the result. The next word can be accepted in the cycle
// after the write-back. One word is in the cache at a time; a new word is
// accepted once the previous one has been written back, even if its result
// still waits on the output, and a write-back waits until the output
// register is free. Lookups report hit and the slot; fills report the
// chosen victim slot with hit low.
// The slot number is reported modulo 256.
module lru_tag_cache_unit #(
  parameter int SLOTS = ltc_pkg::LTC_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [ltc_pkg::LTC_TAG_W-1:0]   in_taxon_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [ltc_pkg::LTC_SLOT_W-1:0]  out_slot
);
  import ltc_pkg::*;

  state_t                 state_r;
  state_t                 state_nxt;
  tok_t                   head;
  tok_t                   tok [SLOTS];
  tok_t                   res_r;
  wr_t                    wr;
  logic [LTC_STAMP_W-1:0] clock_r;
  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [LTC_SLOT_W-1:0]  out_slot_r;
  logic                   in_acc;
  logic                   wb_go;
  logic [LTC_IDX_W-1:0]   res_idx;
  logic [LTC_IDX_W+LTC_SLOT_W-1:0] res_ext;
  logic [SLOTS-1:0]       vld_vec;

  assign in_acc = in_valid && in_ready;
  assign wb_go  = (state_r == S_WB) && (!out_valid_r || out_ready);

  // Token entering the first cell.
  always_comb begin
    head         = '0;
    head.vld     = in_acc;
    head.req     = in_req_type;
    head.id      = in_taxon_id;
    head.vstamp  = '1;
  end

  // Chain of slot cells.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    if (g == 0) begin : g_first
      ltc_cell #(.IDX(g)) u_cell (
        .clk(clk), .rst_n(rst_n), .tok_i(head), .tok_o(tok[g]), .wr_i(wr)
      );
    end else begin : g_rest
      ltc_cell #(.IDX(g)) u_cell (
        .clk(clk), .rst_n(rst_n), .tok_i(tok[g-1]), .tok_o(tok[g]), .wr_i(wr)
      );
    end
    assign vld_vec[g] = tok[g].vld;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SCAN;
      S_SCAN: if (tok[SLOTS-1].vld) state_nxt = S_WB;
      S_WB:   if (wb_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake and write-back outputs.
  always_comb begin
    in_ready = 1'b0;
    wr       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_WB: begin
        wr.en    = wb_go && (res_r.req == REQ_FILL || res_r.found);
        wr.fill  = (res_r.req == REQ_FILL);
        wr.idx   = res_idx;
        wr.tag   = res_r.id;
        wr.stamp = clock_r + LTC_STAMP_W'(1);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Reported slot of the finished word.
  assign res_idx = (res_r.req == REQ_FILL) ? res_r.vidx :
                   (res_r.found ? res_r.fidx : '0);
  assign res_ext = {{LTC_SLOT_W{1'b0}}, res_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr.en) begin
        clock_r <= wr.stamp;
      end
      if (wb_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Captured token and result payload.
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && tok[SLOTS-1].vld) begin
      res_r <= tok[SLOTS-1];
    end
    if (wb_go) begin
      out_hit_r  <= (res_r.req == REQ_LOOKUP) && res_r.found;
      out_slot_r <= res_ext[LTC_SLOT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_slot  = out_slot_r;

`ifndef SYNTHESIS
  // At most one search token is in the chain.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) <= 1)
    else $error("more than one token in the chain");

  // The chain tail only delivers while scanning.
  a_tail_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[SLOTS-1].vld |-> state_r == S_SCAN)
    else $error("token left the chain outside a scan");

  // An accepted word starts a scan.
  a_acc_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_SCAN)
    else $error("accept did not start a scan");

  // A fill never reports a hit.
  a_fill_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_go && res_r.req == REQ_FILL) |=> !out_hit)
    else $error("fill reported a hit");
`endif

endmodule

// ----- tb/lru_tag_cache_unit_tb.sv -----
// ----------------------------------------------------------------------------
// lru_tag_cache_unit_tb
// Drives lookups and fills into the LRU tag cache through its valid/ready
// channels, predicts each result with a timestamp LRU model of its own and
// compares every result word with the oldest expected one.
// ----------------------------------------------------------------------------
module lru_tag_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ltc_pkg::*;

  localparam int NSLOT = 256;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic       hit;
    logic [7:0] slot;
  } lookup_res_t;

  // Scoreboard: an LRU cache model plus the queue of pending results.
  class cache_scoreboard;
    logic [31:0] tags [NSLOT];
    bit          vbits [NSLOT];
    logic [63:0] stamps [NSLOT];
    logic [63:0] clock_cnt;
    lookup_res_t pending [$];
    int          mismatches;

    function void clear();
      for (int i = 0; i < NSLOT; i++) begin
        tags[i] = '0;
        vbits[i] = 0;
        stamps[i] = '0;
      end
      clock_cnt = '0;
      mismatches = 0;
    endfunction

    // Scan for the victim: first invalid slot from 1, else oldest stamp.
    function int choose_victim();
      int vic;
      vic = 0;
      for (int i = 1; i < NSLOT; i++) begin
        if (!vbits[i]) return i;
        if (stamps[i] < stamps[vic]) vic = i;
      end
      return vic;
    endfunction

    // Note an accepted input word and queue its expected result.
    function void note_request(logic req, logic [31:0] id);
      lookup_res_t r;
      int v;
      r.hit = 1'b0;
      r.slot = '0;
      if (req == REQ_LOOKUP) begin
        for (int i = 0; i < NSLOT; i++) begin
          if (vbits[i] && tags[i] == id) begin
            clock_cnt++;
            stamps[i] = clock_cnt;
            r.hit = 1'b1;
            r.slot = i[7:0];
            break;
          end
        end
      end else begin
        v = choose_victim();
        tags[v] = id;
        vbits[v] = 1;
        clock_cnt++;
        stamps[v] = clock_cnt;
        r.slot = v[7:0];
      end
      pending.push_back(r);
    endfunction

    // Check one result word against the oldest expectation.
    function void check_result(logic hit, logic [7:0] slot);
      lookup_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: hit=%0d slot=%0d", hit, slot);
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit || slot !== e.slot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected hit=%0d slot=%0d, got hit=%0d slot=%0d",
                   e.hit, e.slot, hit, slot);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [31:0] in_taxon_id;
  logic        out_valid;
  logic        out_ready;
  logic        out_hit;
  logic [7:0]  out_slot;

  cache_scoreboard sb;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_off;
  longint cycles;
  logic [31:0] known_ids [$];

  lru_tag_cache_unit #(.SLOTS(NSLOT)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_taxon_id(in_taxon_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_slot(out_slot)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle counter with a hard limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Sample accepted result words at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_hit, out_slot);
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one word and hold it until accepted; random gaps before it.
  // Valid stays high after the accept until the next call decides whether
  // to idle, and the caller drops it after the last word.
  task automatic send_word(logic req, logic [31:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_taxon_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req, id);
    if (req == REQ_FILL) known_ids.push_back(id);
    @(negedge clk);
  endtask

  // Random word: mostly lookups of known ids and fills, some noise ids.
  task automatic send_random();
    int k;
    logic [31:0] id;
    k = $urandom_range(99);
    if (k < 35 && known_ids.size() > 0)
      send_word(REQ_LOOKUP, known_ids[$urandom_range(known_ids.size() - 1)]);
    else if (k < 50)
      send_word(REQ_LOOKUP, $urandom);
    else begin
      // Small id pool makes duplicate fills and repeat hits common.
      id = ($urandom_range(3) == 0) ? $urandom : $urandom_range(400);
      send_word(REQ_FILL, id);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_LOOKUP;
    in_taxon_id = '0;
    hold_off = 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 55;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: miss on empty cache, extreme ids, duplicates.
    send_word(REQ_LOOKUP, 32'h0);
    send_word(REQ_LOOKUP, 32'hFFFF_FFFF);
    send_word(REQ_FILL, 32'hFFFF_FFFF);
    send_word(REQ_FILL, 32'h0);
    send_word(REQ_FILL, 32'hFFFF_FFFF);
    send_word(REQ_LOOKUP, 32'hFFFF_FFFF);
    send_word(REQ_LOOKUP, 32'h0);
    send_word(REQ_LOOKUP, 32'hAAAA_5555);
    send_word(REQ_FILL, 32'h5555_AAAA);
    send_word(REQ_LOOKUP, 32'h5555_AAAA);

    // Fill the whole cache so that slot 0 and LRU eviction come into play.
    hold_off = 1'b1;
    fork
      begin
        repeat (2000) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 300; i++) send_word(REQ_FILL, 32'h1000_0000 + i);
    join

    for (int n = 0; n < 300; n++) begin
      if (n == 100) begin
        send_idle_pct = 55;
        recv_idle_pct = 9;
      end
      if (n == 200) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random();
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NSLOT + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
